@@ hdl/hsha_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsha_pkg
// Shared types and constants for the HMAC-SHA1 engine.
// ============================================================================
package hsha_pkg;

    localparam int unsigned BLOCK_BYTES = 64;

    localparam logic OP_KEY = 1'b0;
    localparam logic OP_MSG = 1'b1;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5C;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef logic [4:0][31:0] words_t;

    localparam words_t SHA_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

    // One input transaction.
    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } in_t;

    // One result transaction.
    typedef struct packed {
        logic [31:0] digest_word;
        logic        word_last;
    } out_t;

    // Command queued from the front to the back; same fields as an input item.
    typedef in_t cmd_t;

    // Control from the sequencer to the compression unit.
    typedef struct packed {
        logic        init_cv;
        logic        wr_en;
        logic [5:0]  wr_pos;
        logic [7:0]  wr_byte;
        logic        len_en;
        logic [63:0] len_bits;
        logic        start;
    } core_ctrl_t;

    // Byte of a digest at byte position pos (0..19), big-endian.
    function automatic logic [7:0] digest_byte(input words_t d, input logic [4:0] pos);
        logic [31:0] w;
        logic [7:0]  b;
        w = d[pos[4:2]];
        unique case (pos[1:0])
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

endpackage

@@ hdl/hsha_fifo.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsha_fifo
// Short command queue between the front classifier and the back sequencer.
// ============================================================================
module hsha_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hsha_pkg::cmd_t wdata,
    input  logic          pop,
    output hsha_pkg::cmd_t rdata,
    output logic          full,
    output logic          empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    hsha_pkg::cmd_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]        wptr_reg, wptr_next;
    logic [PTR_W-1:0]        rptr_reg, rptr_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

@@ hdl/hsha_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsha_front
// Accepts input transactions, drops those that do nothing, queues the rest.
// ============================================================================
module hsha_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  hsha_pkg::in_t  item,
    input  logic           full,
    output logic           push,
    output hsha_pkg::cmd_t cmd
);

    // Low while awaiting the key, high while the message streams.
    logic msg_phase_reg, msg_phase_next;
    logic take, relevant;

    assign item_stall = full;
    assign take       = item_valid && !full;
    assign relevant   = (item.opcode == (msg_phase_reg ? hsha_pkg::OP_MSG : hsha_pkg::OP_KEY))
                        && (item.has_byte || item.last);
    assign push       = take && relevant;
    assign cmd        = item;

    always_comb
    begin
        msg_phase_next = msg_phase_reg;
        if (push && item.last)
        begin
            msg_phase_next = !msg_phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_phase_reg <= 1'b0;
        end
        else
        begin
            msg_phase_reg <= msg_phase_next;
        end
    end

endmodule

@@ hdl/hsha_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsha_core
// SHA-1 compression unit: one round per cycle over a 16-word window.
// ============================================================================
module hsha_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hsha_pkg::core_ctrl_t ctrl,
    output logic                 busy,
    output hsha_pkg::words_t     cv
);

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    logic [15:0][31:0] w_reg, w_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [6:0]  round_reg, round_next;
    logic        busy_reg, busy_next;
    hsha_pkg::words_t cv_reg, cv_next;
    logic [31:0] f, k, t, wnew;

    assign busy = busy_reg;
    assign cv   = cv_reg;

    always_comb
    begin
        w_next     = w_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        cv_next    = cv_reg;
        f = 32'h0;
        k = 32'h0;
        priority if (round_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (round_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (round_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        t    = rotl(a_reg, 5) + f + e_reg + k + w_reg[0];
        wnew = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);

        if (busy_reg)
        begin
            if (round_reg != 7'd80)
            begin
                e_next = d_reg;
                d_next = c_reg;
                c_next = rotl(b_reg, 30);
                b_next = a_reg;
                a_next = t;
                w_next = {wnew, w_reg[15:1]};
                round_next = round_reg + 7'd1;
            end
            else
            begin
                cv_next[0] = cv_reg[0] + a_reg;
                cv_next[1] = cv_reg[1] + b_reg;
                cv_next[2] = cv_reg[2] + c_reg;
                cv_next[3] = cv_reg[3] + d_reg;
                cv_next[4] = cv_reg[4] + e_reg;
                busy_next  = 1'b0;
            end
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                unique case (ctrl.wr_pos[1:0])
                    2'd0:    w_next[ctrl.wr_pos[5:2]][31:24] = ctrl.wr_byte;
                    2'd1:    w_next[ctrl.wr_pos[5:2]][23:16] = ctrl.wr_byte;
                    2'd2:    w_next[ctrl.wr_pos[5:2]][15:8]  = ctrl.wr_byte;
                    default: w_next[ctrl.wr_pos[5:2]][7:0]   = ctrl.wr_byte;
                endcase
            end
            if (ctrl.len_en)
            begin
                w_next[14] = ctrl.len_bits[63:32];
                w_next[15] = ctrl.len_bits[31:0];
            end
            if (ctrl.start)
            begin
                a_next     = cv_reg[0];
                b_next     = cv_reg[1];
                c_next     = cv_reg[2];
                d_next     = cv_reg[3];
                e_next     = cv_reg[4];
                round_next = 7'd0;
                busy_next  = 1'b1;
            end
            if (ctrl.init_cv)
            begin
                cv_next = hsha_pkg::SHA_IV;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= '0;
            cv_reg    <= hsha_pkg::SHA_IV;
        end
        else
        begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
            cv_reg    <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

endmodule

@@ hdl/hsha_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsha_back
// Sequencer that carries out queued commands: key storage, padding,
// inner and outer hash, and delivery of the five digest words.
// ============================================================================
module hsha_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  hsha_pkg::cmd_t       head,
    output logic                 pop,
    output hsha_pkg::core_ctrl_t core_ctrl,
    input  logic                 core_busy,
    input  hsha_pkg::words_t     cv,
    output logic                 digest_valid,
    input  logic                 digest_stall,
    output hsha_pkg::out_t       digest
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_HAS     = 4'd1;
    localparam logic [3:0] S_LAST    = 4'd2;
    localparam logic [3:0] S_SWEEP   = 4'd3;
    localparam logic [3:0] S_PAD80   = 4'd4;
    localparam logic [3:0] S_PADZ    = 4'd5;
    localparam logic [3:0] S_LEN     = 4'd6;
    localparam logic [3:0] S_FWAIT   = 4'd7;
    localparam logic [3:0] S_KEYDIG  = 4'd8;
    localparam logic [3:0] S_KEYWR   = 4'd9;
    localparam logic [3:0] S_START36 = 4'd10;
    localparam logic [3:0] S_INNER   = 4'd11;
    localparam logic [3:0] S_IDIG    = 4'd12;
    localparam logic [3:0] S_EMIT    = 4'd13;

    localparam logic [5:0] LAST_POS = 6'(hsha_pkg::BLOCK_BYTES - 1);
    localparam logic [5:0] LEN_POS  = 6'(hsha_pkg::BLOCK_BYTES - 8);

    logic [3:0]  state_reg, state_next;
    logic [3:0]  sweep_ret_reg, sweep_ret_next;
    logic [3:0]  fin_ret_reg, fin_ret_next;
    hsha_pkg::cmd_t cmd_reg, cmd_next;
    logic [6:0]  key_len_reg, key_len_next;
    logic        long_reg, long_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic [6:0]  sweep_idx_reg, sweep_idx_next;
    logic        pipe_v_reg, pipe_v_next;
    logic [7:0]  mask_reg, mask_next;
    logic [4:0]  idx_reg, idx_next;
    hsha_pkg::words_t inner_reg, inner_next;
    logic        out_valid_reg, out_valid_next;
    hsha_pkg::out_t out_reg, out_next;

    // Key store: memory with one valid bit per entry, registered read.
    logic [7:0]  key_mem [hsha_pkg::BLOCK_BYTES];
    logic [63:0] key_vld_reg;
    logic [7:0]  rd_data_reg;
    logic        rd_vld_reg;
    logic        km_we, km_clr;
    logic [5:0]  km_addr;
    logic [7:0]  km_data;

    logic        hb_en, pb_en, do_sweep;
    logic [7:0]  hb_byte, sweep_mask;
    logic [3:0]  sweep_ret;

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        sweep_ret_next = sweep_ret_reg;
        fin_ret_next   = fin_ret_reg;
        cmd_next       = cmd_reg;
        key_len_next   = key_len_reg;
        long_next      = long_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        sweep_idx_next = sweep_idx_reg;
        pipe_v_next    = pipe_v_reg;
        mask_next      = mask_reg;
        idx_next       = idx_reg;
        inner_next     = inner_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && digest_stall;
        pop        = 1'b0;
        km_we      = 1'b0;
        km_clr     = 1'b0;
        km_addr    = key_len_reg[5:0];
        km_data    = cmd_reg.data_byte;
        hb_en      = 1'b0;
        pb_en      = 1'b0;
        hb_byte    = 8'h00;
        do_sweep   = 1'b0;
        sweep_mask = 8'h00;
        sweep_ret  = S_IDLE;
        core_ctrl  = '0;
        core_ctrl.wr_pos   = fill_reg;
        core_ctrl.len_bits = {count_reg, 3'b000};

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = head;
                    state_next = S_HAS;
                end
            end
            S_HAS:
            begin
                if (!core_busy)
                begin
                    priority if (!cmd_reg.has_byte)
                    begin
                        state_next = S_LAST;
                    end
                    else if (cmd_reg.opcode == hsha_pkg::OP_MSG || long_reg)
                    begin
                        hb_en      = 1'b1;
                        hb_byte    = cmd_reg.data_byte;
                        state_next = S_LAST;
                    end
                    else if (!key_len_reg[6])
                    begin
                        km_we        = 1'b1;
                        key_len_next = key_len_reg + 7'd1;
                        state_next   = S_LAST;
                    end
                    else
                    begin
                        // Key overflows one block: hash what is stored so far.
                        long_next = 1'b1;
                        do_sweep  = 1'b1;
                        sweep_ret = S_HAS;
                    end
                end
            end
            S_LAST:
            begin
                priority if (!cmd_reg.last)
                begin
                    state_next = S_IDLE;
                end
                else if (cmd_reg.opcode == hsha_pkg::OP_KEY && !long_reg)
                begin
                    state_next = S_START36;
                end
                else
                begin
                    fin_ret_next = (cmd_reg.opcode == hsha_pkg::OP_KEY) ? S_KEYDIG : S_INNER;
                    state_next   = S_PAD80;
                end
            end
            S_SWEEP:
            begin
                pipe_v_next    = !sweep_idx_reg[6];
                sweep_idx_next = sweep_idx_reg + {6'd0, !sweep_idx_reg[6]};
                if (pipe_v_reg)
                begin
                    hb_en   = 1'b1;
                    hb_byte = (rd_vld_reg ? rd_data_reg : 8'h00) ^ mask_reg;
                    if (fill_reg == LAST_POS)
                    begin
                        pipe_v_next = 1'b0;
                        state_next  = sweep_ret_reg;
                    end
                end
            end
            S_PAD80:
            begin
                if (!core_busy)
                begin
                    pb_en      = 1'b1;
                    hb_byte    = hsha_pkg::PAD_MARK;
                    state_next = S_PADZ;
                end
            end
            S_PADZ:
            begin
                if (!core_busy)
                begin
                    if (fill_reg == LEN_POS)
                    begin
                        state_next = S_LEN;
                    end
                    else
                    begin
                        pb_en = 1'b1;
                    end
                end
            end
            S_LEN:
            begin
                if (!core_busy)
                begin
                    core_ctrl.len_en = 1'b1;
                    core_ctrl.start  = 1'b1;
                    fill_next        = '0;
                    state_next       = S_FWAIT;
                end
            end
            S_FWAIT:
            begin
                if (!core_busy)
                begin
                    state_next = fin_ret_reg;
                end
            end
            S_KEYDIG:
            begin
                km_clr       = 1'b1;
                key_len_next = 7'd20;
                idx_next     = '0;
                state_next   = S_KEYWR;
            end
            S_KEYWR:
            begin
                km_we    = 1'b1;
                km_addr  = {1'b0, idx_reg};
                km_data  = hsha_pkg::digest_byte(cv, idx_reg);
                idx_next = idx_reg + 5'd1;
                if (idx_reg == 5'd19)
                begin
                    state_next = S_START36;
                end
            end
            S_START36:
            begin
                if (!core_busy)
                begin
                    do_sweep   = 1'b1;
                    sweep_mask = hsha_pkg::IPAD;
                    sweep_ret  = S_IDLE;
                end
            end
            S_INNER:
            begin
                inner_next = cv;
                idx_next   = '0;
                do_sweep   = 1'b1;
                sweep_mask = hsha_pkg::OPAD;
                sweep_ret  = S_IDIG;
            end
            S_IDIG:
            begin
                if (!core_busy)
                begin
                    hb_en    = 1'b1;
                    hb_byte  = hsha_pkg::digest_byte(inner_reg, idx_reg);
                    idx_next = idx_reg + 5'd1;
                    if (idx_reg == 5'd19)
                    begin
                        idx_next     = '0;
                        fin_ret_next = S_EMIT;
                        state_next   = S_PAD80;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !digest_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_next.digest_word = cv[idx_reg[2:0]];
                    out_next.word_last   = (idx_reg == 5'd4);
                    idx_next             = idx_reg + 5'd1;
                    if (idx_reg == 5'd4)
                    begin
                        // Back to the state after reset.
                        idx_next          = '0;
                        km_clr            = 1'b1;
                        key_len_next      = '0;
                        long_next         = 1'b0;
                        fill_next         = '0;
                        count_next        = '0;
                        core_ctrl.init_cv = 1'b1;
                        state_next        = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_sweep)
        begin
            core_ctrl.init_cv = 1'b1;
            fill_next         = '0;
            count_next        = '0;
            sweep_idx_next    = '0;
            pipe_v_next       = 1'b0;
            mask_next         = sweep_mask;
            sweep_ret_next    = sweep_ret;
            state_next        = S_SWEEP;
        end

        if (hb_en || pb_en)
        begin
            core_ctrl.wr_en   = 1'b1;
            core_ctrl.wr_byte = hb_byte;
            fill_next         = fill_reg + 6'd1;
            if (fill_reg == LAST_POS)
            begin
                core_ctrl.start = 1'b1;
            end
        end
        if (hb_en && count_reg != '1)
        begin
            count_next = count_reg + 61'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sweep_ret_reg <= S_IDLE;
            fin_ret_reg   <= S_IDLE;
            key_len_reg   <= '0;
            long_reg      <= 1'b0;
            fill_reg      <= '0;
            count_reg     <= '0;
            sweep_idx_reg <= '0;
            pipe_v_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            key_vld_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_ret_reg <= sweep_ret_next;
            fin_ret_reg   <= fin_ret_next;
            key_len_reg   <= key_len_next;
            long_reg      <= long_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            sweep_idx_reg <= sweep_idx_next;
            pipe_v_reg    <= pipe_v_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (km_clr)
            begin
                key_vld_reg <= '0;
            end
            else if (km_we)
            begin
                key_vld_reg[km_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        mask_reg    <= mask_next;
        inner_reg   <= inner_next;
        out_reg     <= out_next;
        if (km_we)
        begin
            key_mem[km_addr] <= km_data;
        end
        rd_data_reg <= key_mem[sweep_idx_reg[5:0]];
        rd_vld_reg  <= key_vld_reg[sweep_idx_reg[5:0]];
    end

endmodule

@@ hdl/hmac_sha1_engine_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hmac_sha1_engine_top
// Streaming HMAC-SHA1 engine: key bytes, then message bytes, in; five
// big-endian digest words out.
// ============================================================================
//
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-------------------------------------
//  item     | item_valid / item_stall   | opcode, data_byte, has_byte, last
//  digest   | digest_valid / digest_stall | digest_word, word_last
//
// A transaction is taken at a rising edge with valid high and stall low.
// A plain key or message byte costs one queue slot and passes through the
// sequencer's pop, write and end-check states; once a 64-byte block fills,
// the next byte waits for the compression (80 rounds and the chaining
// update). Key end costs a pad sweep (a key-store read, then 64 writes) that
// starts one block; a long key first adds a padded finish and 20 digest-byte
// writes. Message end costs two padded finishes and an outer key sweep, plus
// a further compression when the inner padding spills into another block.
// Reset clears all control state at once; there is no clearing pass.
// item_stall rises only when the command queue is full; digest_stall holds
// the output register and, behind it, the sequencer.
//
module hmac_sha1_engine_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  hsha_pkg::in_t   item,
    output logic            digest_valid,
    input  logic            digest_stall,
    output hsha_pkg::out_t  digest
);

    hsha_pkg::cmd_t       push_cmd;
    hsha_pkg::cmd_t       head_cmd;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    hsha_pkg::core_ctrl_t core_ctrl;
    logic                 core_busy;
    hsha_pkg::words_t     cv;

    // The front tracks the key/message phase itself and drops transactions
    // that the engine would ignore, so the queue only holds real work.
    hsha_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .full       (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    hsha_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_cmd),
        .pop   (pop),
        .rdata (head_cmd),
        .full  (q_full),
        .empty (q_empty)
    );

    // The back sequences key storage, padding and both hash passes.
    hsha_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .head         (head_cmd),
        .pop          (pop),
        .core_ctrl    (core_ctrl),
        .core_busy    (core_busy),
        .cv           (cv),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    hsha_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .busy  (core_busy),
        .cv    (cv)
    );

    // A block may only be started while the compression unit is free.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        core_ctrl.start |-> !core_busy)
        else $error("compression started while busy");

    // The window must not be written while rounds are running.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (core_ctrl.wr_en || core_ctrl.len_en || core_ctrl.init_cv) |-> !core_busy)
        else $error("block buffer written during compression");

    // The sequencer never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty command queue");

endmodule

@@ verif/tb_hmac_sha1_engine_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_hmac_sha1_engine_top
// Self-checking bench for the HMAC-SHA1 engine. It streams keys and messages
// into the block, predicts every digest word with a behavioural HMAC-SHA1
// model kept in a small class, and compares each word leaving the block.
// ============================================================================
module tb_hmac_sha1_engine_top;

    typedef bit [4:0][31:0] sha_words_t;

    // Behavioural HMAC-SHA1 predictor. It holds its own copy of the engine
    // state and queues the five words that each finished message produces.
    class hmac_digest_model;
        bit [7:0]        key_blk [64];
        int unsigned     key_len;
        bit              key_long;
        bit [31:0]       chain [5];
        bit [7:0]        blk_buf [64];
        longint unsigned byte_cnt;
        int unsigned     fill;
        bit              in_message;
        hsha_pkg::out_t  words_due [$];
        int unsigned     mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            foreach (key_blk[i]) key_blk[i] = 8'h00;
            foreach (blk_buf[i]) blk_buf[i] = 8'h00;
            key_len    = 0;
            key_long   = 1'b0;
            in_message = 1'b0;
            start_hash();
        endfunction

        function void start_hash();
            for (int i = 0; i < 5; i++) chain[i] = hsha_pkg::SHA_IV[i];
            byte_cnt = 0;
            fill     = 0;
        endfunction

        function void compress();
            bit [31:0] w [80];
            bit [31:0] a, b, c, d, e, f, k, t;
            for (int i = 0; i < 16; i++)
                w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
            for (int i = 16; i < 80; i++)
            begin
                t    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
                w[i] = {t[30:0], t[31]};
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int i = 0; i < 80; i++)
            begin
                if (i < 20)
                begin
                    f = (b & c) | (~b & d); k = 32'h5A827999;
                end
                else if (i < 40)
                begin
                    f = b ^ c ^ d; k = 32'h6ED9EBA1;
                end
                else if (i < 60)
                begin
                    f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
                end
                else
                begin
                    f = b ^ c ^ d; k = 32'hCA62C1D6;
                end
                t = {a[26:0], a[31:27]} + f + e + k + w[i];
                e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void absorb(bit [7:0] v);
            blk_buf[fill] = v;
            fill = (fill + 1) % 64;
            if (fill == 0) compress();
            if (byte_cnt < 64'h1FFF_FFFF_FFFF_FFFF) byte_cnt++;
        endfunction

        function sha_words_t finish_hash();
            bit [63:0]   bits;
            int unsigned pos;
            sha_words_t  r;
            bits = byte_cnt << 3;
            pos  = fill;
            blk_buf[pos++] = hsha_pkg::PAD_MARK;
            if (pos > 56)
            begin
                while (pos < 64) blk_buf[pos++] = 8'h00;
                compress();
                pos = 0;
            end
            while (pos < 56) blk_buf[pos++] = 8'h00;
            for (int i = 0; i < 8; i++) blk_buf[56+i] = bits[63-8*i -: 8];
            compress();
            for (int i = 0; i < 5; i++) r[i] = chain[i];
            return r;
        endfunction

        function void close_key();
            sha_words_t kd;
            if (key_long)
            begin
                kd = finish_hash();
                foreach (key_blk[i]) key_blk[i] = 8'h00;
                for (int i = 0; i < 20; i++) key_blk[i] = kd[i/4][31-8*(i%4) -: 8];
                key_len = 20;
            end
            start_hash();
            for (int i = 0; i < 64; i++) absorb(key_blk[i] ^ hsha_pkg::IPAD);
            in_message = 1'b1;
        endfunction

        function void add_key_byte(bit [7:0] v);
            if (key_long)
                absorb(v);
            else if (key_len < 64)
                key_blk[key_len++] = v;
            else
            begin
                key_long = 1'b1;
                start_hash();
                for (int i = 0; i < 64; i++) absorb(key_blk[i]);
                absorb(v);
            end
        endfunction

        // Called for every accepted input transaction.
        function void note_item(hsha_pkg::in_t it);
            sha_words_t     inner, outer;
            hsha_pkg::out_t o;
            if (!in_message)
            begin
                if (it.opcode != hsha_pkg::OP_KEY) return;
                if (it.has_byte) add_key_byte(it.data_byte);
                if (it.last) close_key();
                return;
            end
            if (it.opcode != hsha_pkg::OP_MSG) return;
            if (it.has_byte) absorb(it.data_byte);
            if (!it.last) return;
            inner = finish_hash();
            start_hash();
            for (int i = 0; i < 64; i++) absorb(key_blk[i] ^ hsha_pkg::OPAD);
            for (int i = 0; i < 20; i++) absorb(inner[i/4][31-8*(i%4) -: 8]);
            outer = finish_hash();
            for (int i = 0; i < 5; i++)
            begin
                o.digest_word = outer[i];
                o.word_last   = (i == 4);
                words_due.push_back(o);
            end
            clear();
        endfunction

        // Called for every accepted digest transaction.
        function void check_word(hsha_pkg::out_t got);
            hsha_pkg::out_t want;
            if (words_due.size() == 0)
            begin
                $error("digest_word %h arrived with no word expected", got.digest_word);
                mismatches++;
                return;
            end
            want = words_due.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
                mismatches++;
            end
            if (got.word_last !== want.word_last)
            begin
                $error("word_last: expected %b, got %b", want.word_last, got.word_last);
                mismatches++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           item_valid;
    logic           item_stall;
    hsha_pkg::in_t  item;
    logic           digest_valid;
    logic           digest_stall;
    hsha_pkg::out_t digest;

    hmac_digest_model hmac_pred;
    int unsigned      items_sent;
    int unsigned      cycle_count;
    bit               steady;      // when set, neither side idles

    hmac_sha1_engine_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("** hmac_sha1_engine_top: FAILED **");
            $finish;
        end
    end

    // Digest side: every word taken at this edge is checked against the oldest
    // prediction, and outside the steady stretch the stall for the next cycle is drawn at random.
    always @(posedge clk)
    begin
        if (rst_n && digest_valid && !digest_stall)
            hmac_pred.check_word(digest);
        if (!rst_n || steady)
            digest_stall <= 1'b0;
        else
            digest_stall <= ($urandom_range(0, 99) < 16);
    end

    // Presents one transaction and holds it until the engine takes it. An
    // idle gap, when drawn, follows the transaction, so that valid never
    // drops and rises again within the same time step.
    task automatic send_item(logic op, logic [7:0] data, logic has, logic lst);
        hsha_pkg::in_t it;
        it.opcode    = op;
        it.data_byte = data;
        it.has_byte  = has;
        it.last      = lst;
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        hmac_pred.note_item(it);
        items_sent++;
        steady = (items_sent >= 150 && items_sent < 260);
        if (!steady && $urandom_range(0, 99) < 16)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // A whole key followed by a whole message. With noise, stray
    // transactions that the engine must ignore are scattered in.
    task automatic send_hmac(int unsigned klen, int unsigned mlen, bit noise);
        if (noise && $urandom_range(0, 1))
            send_item(hsha_pkg::OP_MSG, 8'($urandom), 1'b1, 1'($urandom));
        if (klen == 0)
            send_item(hsha_pkg::OP_KEY, 8'($urandom), 1'b0, 1'b1);
        for (int unsigned i = 0; i < klen; i++)
        begin
            if (noise && $urandom_range(0, 19) == 0)
                send_item(hsha_pkg::OP_KEY, 8'($urandom), 1'b0, 1'b0);
            send_item(hsha_pkg::OP_KEY, 8'($urandom), 1'b1, (i == klen - 1));
        end
        if (noise && $urandom_range(0, 1))
            send_item(hsha_pkg::OP_KEY, 8'($urandom), 1'($urandom), 1'($urandom));
        if (mlen == 0)
            send_item(hsha_pkg::OP_MSG, 8'($urandom), 1'b0, 1'b1);
        for (int unsigned i = 0; i < mlen; i++)
        begin
            if (noise && $urandom_range(0, 19) == 0)
                send_item(hsha_pkg::OP_KEY, 8'($urandom), 1'b1, 1'($urandom));
            // Now and then the message is closed by an empty transaction.
            if (i == mlen - 1 && $urandom_range(0, 4) == 0)
            begin
                send_item(hsha_pkg::OP_MSG, 8'($urandom), 1'b1, 1'b0);
                send_item(hsha_pkg::OP_MSG, 8'($urandom), 1'b0, 1'b1);
            end
            else
                send_item(hsha_pkg::OP_MSG, 8'($urandom), 1'b1, (i == mlen - 1));
        end
    endtask

    initial
    begin
        int unsigned klen, mlen;
        hmac_pred    = new();
        items_sent   = 0;
        cycle_count  = 0;
        steady       = 1'b0;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        digest_stall <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: an empty key and an empty message first.
        send_item(hsha_pkg::OP_KEY, 8'h00, 1'b0, 1'b1);
        send_item(hsha_pkg::OP_MSG, 8'hFF, 1'b0, 1'b1);
        // Stray message transaction before any key, and an empty no-op.
        send_item(hsha_pkg::OP_MSG, 8'hA5, 1'b1, 1'b1);
        send_item(hsha_pkg::OP_KEY, 8'h5A, 1'b0, 1'b0);
        // Short key at the byte extremes.
        send_item(hsha_pkg::OP_KEY, 8'h00, 1'b1, 1'b0);
        send_item(hsha_pkg::OP_KEY, 8'hFF, 1'b1, 1'b0);
        send_item(hsha_pkg::OP_KEY, 8'h80, 1'b1, 1'b1);
        // Key transaction during the message is ignored, last included.
        send_item(hsha_pkg::OP_KEY, 8'h11, 1'b1, 1'b1);
        send_item(hsha_pkg::OP_MSG, 8'hFF, 1'b1, 1'b0);
        send_item(hsha_pkg::OP_MSG, 8'h00, 1'b1, 1'b0);
        send_item(hsha_pkg::OP_MSG, 8'h7F, 1'b0, 1'b0);
        send_item(hsha_pkg::OP_MSG, 8'h01, 1'b0, 1'b1);

        // Random part: mostly well-formed key and message pairs, with key
        // sizes around the block boundary and message sizes around the
        // padding boundaries, plus ignored transactions as noise.
        while (items_sent < 400)
        begin
            case ($urandom_range(0, 9))
                0:       klen = 0;
                1:       klen = 64;
                2:       klen = $urandom_range(65, 140);
                default: klen = $urandom_range(1, 63);
            endcase
            case ($urandom_range(0, 9))
                0:       mlen = 0;
                1:       mlen = $urandom_range(55, 56);
                2:       mlen = 64;
                3:       mlen = $urandom_range(119, 120);
                default: mlen = $urandom_range(1, 40);
            endcase
            send_hmac(klen, mlen, ($urandom_range(0, 3) == 0));
        end
        item_valid <= 1'b0;

        // Drain, then give the engine time to show any stray word.
        while (hmac_pred.words_due.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);
        if (hmac_pred.mismatches == 0)
            $display("** hmac_sha1_engine_top: PASSED **");
        else
            $display("** hmac_sha1_engine_top: FAILED **");
        $finish;
    end

endmodule
